/* hw/rtl/wed_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wed_pkg
// Types and constants shared by the weighted OSA edit distance block.
// ----------------------------------------------------------------------------
package wed_pkg;

   localparam logic [1:0] OP_APPEND_A = 2'd0;
   localparam logic [1:0] OP_APPEND_B = 2'd1;
   localparam logic [1:0] OP_COMPUTE  = 2'd2;

   localparam int W_INS    = 1;
   localparam int W_DEL    = 3;
   localparam int W_SUB    = 3;
   localparam int W_XPOSE  = 2;
   localparam int DIST_MAX = 511;

   localparam logic RATIO_ADDR = 1'b0;
   localparam logic [7:0] RATIO_RESET = 8'd3;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] character;
   } req_type;

   typedef struct packed {
      logic [8:0] distance;
      logic       shortcut_taken;
      logic       overflow;
   } rsp_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
      logic init;
      logic comp;
      logic step_col;
      logic step_row;
      logic emit_short;
      logic emit_dist;
   } cmd_type;

   typedef struct packed {
      logic shortcut;
      logic last_col;
      logic last_row;
   } stat_type;

endpackage

/* hw/rtl/wed_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wed_ctrl
// Sequencer: loads, ratio shortcut and the read-then-compute cell walk.
// ----------------------------------------------------------------------------
module wed_ctrl import wed_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  req_type  req_payload,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy,
   output logic     rsp_valid
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_COMP = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_payload.op)
                  OP_APPEND_A: cmd.load_a = 1'b1;
                  OP_APPEND_B: cmd.load_b = 1'b1;
                  OP_COMPUTE: begin
                     if (stat.shortcut) begin
                        cmd.emit_short = 1'b1;
                     end else begin
                        cmd.init = 1'b1;
                        state_in = ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: state_in = ST_COMP;
         ST_COMP: begin
            cmd.comp = 1'b1;
            if (!stat.last_col) begin
               cmd.step_col = 1'b1;
               state_in     = ST_READ;
            end else if (!stat.last_row) begin
               cmd.step_row = 1'b1;
               state_in     = ST_READ;
            end else begin
               cmd.emit_dist = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      valid_in = cmd.emit_short | cmd.emit_dist;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;

endmodule

/* hw/rtl/wed_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wed_datapath
// String stores, three rotating row memories and the cell update.
// ----------------------------------------------------------------------------
module wed_datapath import wed_pkg::*; #(
   parameter int MAX_LEN = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_payload,
   input  logic [7:0] ratio_limit,
   input  cmd_type    cmd,
   output stat_type   stat,
   output rsp_type    rsp_payload
);

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int AW = $clog2(MAX_LEN);
   localparam int VW = $clog2(4 * MAX_LEN + 4);
   localparam int PW = LW + 8;

   logic [7:0] str_a [MAX_LEN];
   logic [7:0] str_b [MAX_LEN];
   logic [VW-1:0] row0 [MAX_LEN + 1];
   logic [VW-1:0] row1 [MAX_LEN + 1];
   logic [VW-1:0] row2 [MAX_LEN + 1];

   logic [LW-1:0] len_a_ff, len_a_in, len_b_ff, len_b_in;
   logic          ovf_ff, ovf_in;
   logic [LW-1:0] i_ff, i_in, j_ff, j_in;
   logic [1:0]    cur_ff, cur_in, prv_ff, prv_in, two_ff, two_in;
   logic [7:0]    a_rd_ff, b_rd_ff;
   logic [VW-1:0] r0_rd_ff, r1_rd_ff, r2_rd_ff;
   logic [7:0]    a_cur_ff, a_prev_ff, b_prev_ff;
   logic [VW-1:0] left_ff, diag_ff;
   rsp_type       rsp_ff;

   logic [LW-1:0] jm2, im1, jm1;
   logic [VW-1:0] prv_data, two_data, d, d3i;
   logic [7:0]    a_cur;
   logic [PW-1:0] prod_a, prod_b;
   logic [LW-1:0] longer;

   assign jm1 = j_ff - 1'b1;
   assign jm2 = j_ff - LW'(2);
   assign im1 = i_ff - 1'b1;

   // ratio shortcut test
   assign prod_a = PW'(len_a_ff) * PW'(ratio_limit);
   assign prod_b = PW'(len_b_ff) * PW'(ratio_limit);
   assign stat.shortcut = (prod_a < PW'(len_b_ff)) || (prod_b < PW'(len_a_ff));
   assign stat.last_col = (j_ff == len_b_ff);
   assign stat.last_row = (i_ff == len_a_ff);
   assign longer = (len_a_ff > len_b_ff) ? len_a_ff : len_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_a && len_a_ff < LW'(MAX_LEN)) str_a[len_a_ff[AW-1:0]] <= req_payload.character;
      if (cmd.load_b && len_b_ff < LW'(MAX_LEN)) str_b[len_b_ff[AW-1:0]] <= req_payload.character;
      a_rd_ff <= str_a[im1[AW-1:0]];
      b_rd_ff <= str_b[jm1[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.comp && cur_ff == 2'd0) row0[j_ff] <= d;
      if (cmd.comp && cur_ff == 2'd1) row1[j_ff] <= d;
      if (cmd.comp && cur_ff == 2'd2) row2[j_ff] <= d;
      r0_rd_ff <= row0[(prv_ff == 2'd0) ? j_ff : jm2];
      r1_rd_ff <= row1[(prv_ff == 2'd1) ? j_ff : jm2];
      r2_rd_ff <= row2[(prv_ff == 2'd2) ? j_ff : jm2];
   end

   always_comb begin
      case (prv_ff)
         2'd0:    prv_data = r0_rd_ff;
         2'd1:    prv_data = r1_rd_ff;
         default: prv_data = r2_rd_ff;
      endcase
      case (two_ff)
         2'd0:    two_data = r0_rd_ff;
         2'd1:    two_data = r1_rd_ff;
         default: two_data = r2_rd_ff;
      endcase
   end

   // a[i-1] arrives with the first cell of each row
   assign a_cur = (j_ff == '0) ? a_rd_ff : a_cur_ff;
   assign d3i   = VW'(i_ff) * VW'(W_DEL);

   always_comb begin
      if (j_ff == '0) begin
         d = d3i;
      end else if (i_ff == '0) begin
         d = VW'(j_ff);
      end else begin
         d = prv_data + VW'(W_DEL);
         if (left_ff + VW'(W_INS) < d) d = left_ff + VW'(W_INS);
         if (diag_ff + VW'(W_SUB) < d) d = diag_ff + VW'(W_SUB);
         if (a_cur == b_rd_ff && diag_ff < d) d = diag_ff;
         if (i_ff >= LW'(2) && j_ff >= LW'(2) && a_prev_ff == b_rd_ff &&
             a_cur == b_prev_ff && two_data + VW'(W_XPOSE) < d)
            d = two_data + VW'(W_XPOSE);
      end
   end

   always_comb begin
      len_a_in = len_a_ff;
      len_b_in = len_b_ff;
      ovf_in   = ovf_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      cur_in   = cur_ff;
      prv_in   = prv_ff;
      two_in   = two_ff;
      if (cmd.load_a) begin
         if (len_a_ff < LW'(MAX_LEN)) len_a_in = len_a_ff + 1'b1;
         else ovf_in = 1'b1;
      end
      if (cmd.load_b) begin
         if (len_b_ff < LW'(MAX_LEN)) len_b_in = len_b_ff + 1'b1;
         else ovf_in = 1'b1;
      end
      if (cmd.init) begin
         i_in   = '0;
         j_in   = '0;
         cur_in = 2'd0;
         prv_in = 2'd1;
         two_in = 2'd2;
      end
      if (cmd.step_col) j_in = j_ff + 1'b1;
      if (cmd.step_row) begin
         i_in   = i_ff + 1'b1;
         j_in   = '0;
         cur_in = two_ff;
         prv_in = cur_ff;
         two_in = prv_ff;
      end
      if (cmd.emit_short || cmd.emit_dist) begin
         len_a_in = '0;
         len_b_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_a_ff <= '0;
         len_b_ff <= '0;
         ovf_ff   <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         cur_ff   <= 2'd0;
         prv_ff   <= 2'd1;
         two_ff   <= 2'd2;
      end else begin
         len_a_ff <= len_a_in;
         len_b_ff <= len_b_in;
         ovf_ff   <= ovf_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         cur_ff   <= cur_in;
         prv_ff   <= prv_in;
         two_ff   <= two_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.comp) begin
         left_ff   <= d;
         diag_ff   <= prv_data;
         b_prev_ff <= b_rd_ff;
         if (j_ff == '0) begin
            a_cur_ff  <= a_rd_ff;
            a_prev_ff <= a_cur_ff;
         end
      end
      if (cmd.emit_dist) begin
         rsp_ff.distance       <= (32'(d) > 32'(DIST_MAX)) ? 9'(DIST_MAX) : 9'(d);
         rsp_ff.shortcut_taken <= 1'b0;
         rsp_ff.overflow       <= ovf_ff;
      end
      if (cmd.emit_short) begin
         rsp_ff.distance       <= (32'(longer) > 32'(DIST_MAX)) ? 9'(DIST_MAX) : 9'(longer);
         rsp_ff.shortcut_taken <= 1'b1;
         rsp_ff.overflow       <= ovf_ff;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

/* hw/rtl/weighted_osa_edit_distance.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_osa_edit_distance
// Weighted restricted Damerau distance between two loaded byte strings.
// ----------------------------------------------------------------------------
//  channel   signals                          handshake
//  request   start, busy, req_payload         taken when start && !busy
//  result    rsp_valid, rsp_payload           one-cycle strobe, no stall
//  config    psel penable pwrite paddr ...    APB write, pready tied high
//
// Appends never raise busy. A compute that takes the
// ratio shortcut answers the cycle after acceptance without raising busy.
// Otherwise the pass walks (len_a+1)*(len_b+1) cells, each as a
// registered row-memory read followed by the cell update and write back,
// and the result strobes once the last cell has been updated.
// Synchronous reset clears lengths, overflow and control; stores need none.
// ----------------------------------------------------------------------------
module weighted_osa_edit_distance import wed_pkg::*; #(
   parameter int MAX_LEN = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_valid,
   output rsp_type     rsp_payload,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [7:0] ratio_ff, ratio_in;
   cmd_type    cmd;
   stat_type   stat;
   logic       busy_int;

   // ratio limit register, word 0
   always_comb begin
      ratio_in = ratio_ff;
      if (psel && penable && pwrite && paddr[2] == RATIO_ADDR) ratio_in = pwdata[7:0];
   end

   always_ff @(posedge clock) begin
      if (reset) ratio_ff <= RATIO_RESET;
      else       ratio_ff <= ratio_in;
   end

   assign prdata = (paddr[2] == RATIO_ADDR) ? {24'd0, ratio_ff} : 32'd0;
   assign pready = 1'b1;

   wed_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .stat        (stat),
      .cmd         (cmd),
      .busy        (busy_int),
      .rsp_valid   (rsp_valid)
   );

   wed_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .ratio_limit (ratio_ff),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

   assign busy = busy_int;

endmodule

/* hw/rtl/wed_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wed_checker
// Port-level checks on the edit distance block.
// ----------------------------------------------------------------------------
module wed_checker import wed_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_payload,
   input logic    rsp_valid,
   input rsp_type rsp_payload
);

   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_payload.op == OP_APPEND_A || req_payload.op == OP_APPEND_B))
      |=> !rsp_valid) else $error("append produced a result");

   a_compute_acts: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_payload.op == OP_COMPUTE) |=> (busy || rsp_valid))
      else $error("compute neither started a pass nor answered");

   a_pass_end_rsp: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> (rsp_valid && !rsp_payload.shortcut_taken))
      else $error("pass ended without a distance result");

   a_short_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.shortcut_taken) |-> !$past(busy))
      else $error("shortcut result after a pass");

endmodule

bind weighted_osa_edit_distance wed_checker u_wed_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the weighted OSA edit distance block. Strings are
// loaded item by item, computes are predicted by a local dynamic-programming
// model and every result strobe is compared against a queue of expectations.
// ----------------------------------------------------------------------------
module tb_top;
   import wed_pkg::*;

   localparam int MAXL = 64;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_payload;
   logic        rsp_valid;
   rsp_type     rsp_payload;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   weighted_osa_edit_distance #(.MAX_LEN(MAXL)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid),
      .rsp_payload(rsp_payload), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .pready(pready)
   );

   // Predictor state: mirrors the block's strings, lengths and ratio limit.
   logic [7:0] str_a [MAXL];
   logic [7:0] str_b [MAXL];
   int         len_a, len_b;
   logic       dropped;
   logic [7:0] ratio_limit;

   rsp_type    distance_queue[$];
   int         fail_count = 0;
   bit         idle_sender_pause;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Generous cap: about 120 computes plus loads fit far below this.
   initial begin
      #40ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Weighted OSA distance with three rolling rows, or the longer length on a ratio shortcut.
   function automatic rsp_type predict_distance();
      int two_back [MAXL+1];
      int prev_row [MAXL+1];
      int cur_row  [MAXL+1];
      int d;
      int la, lb;
      rsp_type r;
      la = len_a;
      lb = len_b;
      r.overflow = dropped;
      r.shortcut_taken = 1'b0;
      if (la * ratio_limit < lb || lb * ratio_limit < la) begin
         r.shortcut_taken = 1'b1;
         d = (la > lb) ? la : lb;
      end else begin
         for (int i = 0; i <= la; i++) begin
            for (int j = 0; j <= lb; j++) begin
               if (i == 0 || j == 0) begin
                  cur_row[j] = W_DEL * i + W_INS * j;
               end else begin
                  d = prev_row[j] + W_DEL;
                  if (cur_row[j-1] + W_INS < d) d = cur_row[j-1] + W_INS;
                  if (prev_row[j-1] + W_SUB < d) d = prev_row[j-1] + W_SUB;
                  if (str_a[i-1] == str_b[j-1] && prev_row[j-1] < d) d = prev_row[j-1];
                  if (i >= 2 && j >= 2 && str_a[i-2] == str_b[j-1] &&
                      str_a[i-1] == str_b[j-2] && two_back[j-2] + W_XPOSE < d)
                     d = two_back[j-2] + W_XPOSE;
                  cur_row[j] = d;
               end
            end
            two_back = prev_row;
            prev_row = cur_row;
         end
         d = prev_row[lb];
      end
      if (d > DIST_MAX) d = DIST_MAX;
      r.distance = d[8:0];
      return r;
   endfunction

   // Update the predictor for one accepted item.
   task automatic track_item(input logic [1:0] op, input logic [7:0] ch);
      if (op == OP_APPEND_A) begin
         if (len_a < MAXL) begin
            str_a[len_a] = ch;
            len_a = len_a + 1;
         end else dropped = 1'b1;
      end else if (op == OP_APPEND_B) begin
         if (len_b < MAXL) begin
            str_b[len_b] = ch;
            len_b = len_b + 1;
         end else dropped = 1'b1;
      end else if (op == OP_COMPUTE) begin
         distance_queue.push_back(predict_distance());
         len_a = 0;
         len_b = 0;
         dropped = 1'b0;
      end
   endtask

   // Present one item and hold it until accepted. start stays high into the
   // next item of a burst; a gap or a drain drops it.
   task automatic send_item(input logic [1:0] op, input logic [7:0] ch);
      start <= 1'b1;
      req_payload <= '{op: op, character: ch};
      @(posedge clock);
      while (busy) @(posedge clock);
      track_item(op, ch);
      @(negedge clock);
   endtask

   // Random gap after an item; bursts come from runs of zero gaps.
   task automatic sender_gap();
      int n;
      if (idle_sender_pause && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 6);
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
      if ($urandom_range(0, 15) == 0) idle_sender_pause = !idle_sender_pause;
   endtask

   task automatic send_and_gap(input logic [1:0] op, input logic [7:0] ch);
      send_item(op, ch);
      sender_gap();
   endtask

   task automatic drain();
      start <= 1'b0;
      while (distance_queue.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_ratio(input logic [7:0] val);
      drain();
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {RATIO_ADDR, 2'b00}; pwdata <= {24'd0, val};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      ratio_limit = val;
   endtask

   task automatic load_string(input bit to_b, input int n, input int alphabet);
      for (int k = 0; k < n; k++)
         send_and_gap(to_b ? OP_APPEND_B : OP_APPEND_A,
                      alphabet >= 255 ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(0, alphabet)));
   endtask

   // Result checker: the receiver cannot stall, so every strobe is taken.
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid) begin
         if (distance_queue.size() == 0) begin
            $error("unexpected result distance=%0d", rsp_payload.distance);
            fail_count++;
         end else begin
            exp_r = distance_queue.pop_front();
            if (rsp_payload.distance !== exp_r.distance) begin
               $error("distance exp %0d got %0d", exp_r.distance, rsp_payload.distance);
               fail_count++;
            end
            if (rsp_payload.shortcut_taken !== exp_r.shortcut_taken) begin
               $error("shortcut_taken exp %0b got %0b", exp_r.shortcut_taken,
                      rsp_payload.shortcut_taken);
               fail_count++;
            end
            if (rsp_payload.overflow !== exp_r.overflow) begin
               $error("overflow exp %0b got %0b", exp_r.overflow, rsp_payload.overflow);
               fail_count++;
            end
         end
      end
   end

   // Directed: extremes, swap, unused op, empty strings, overflow.
   task automatic test_directed();
      send_and_gap(OP_COMPUTE, 8'h00);              // both empty
      send_and_gap(OP_APPEND_A, 8'h00);
      send_and_gap(OP_COMPUTE, 8'hFF);              // a vs empty: shortcut
      send_and_gap(OP_APPEND_A, 8'hFF);
      send_and_gap(OP_APPEND_A, 8'h00);
      send_and_gap(OP_APPEND_B, 8'h00);
      send_and_gap(OP_APPEND_B, 8'hFF);
      send_and_gap(2'd3, 8'hAA);                    // unused op ignored
      send_and_gap(OP_COMPUTE, 8'h55);              // adjacent swap
      send_and_gap(OP_APPEND_A, 8'h5A);
      send_and_gap(OP_APPEND_B, 8'hA5);
      send_and_gap(OP_COMPUTE, 8'h00);              // replace
      drain();
      // Full strings plus one dropped char each: overflow flagged.
      load_string(1'b0, MAXL + 1, 255);
      load_string(1'b1, MAXL + 1, 255);
      send_and_gap(OP_COMPUTE, 8'h00);
   endtask

   task automatic test_ratio_extremes();
      write_ratio(8'd0);
      load_string(1'b0, 2, 3);
      load_string(1'b1, 2, 3);
      send_and_gap(OP_COMPUTE, 8'h00);
      send_and_gap(OP_COMPUTE, 8'h00);
      write_ratio(8'd1);
      load_string(1'b0, 3, 3);
      load_string(1'b1, 4, 3);
      send_and_gap(OP_COMPUTE, 8'h00);
      write_ratio(8'd255);
      load_string(1'b0, MAXL, 1);
      load_string(1'b1, 1, 1);
      send_and_gap(OP_COMPUTE, 8'h00);
   endtask

   // Random strings, mostly over small alphabets so matches and swaps are common.
   task automatic test_random(input int items);
      int sent = 0;
      int na, nb, alph, pick;
      while (sent < items) begin
         pick = $urandom_range(0, 9);
         na = (pick == 0) ? $urandom_range(40, MAXL + 2) : $urandom_range(0, 12);
         nb = (pick == 1) ? $urandom_range(40, MAXL + 2) : $urandom_range(0, 12);
         alph = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 3);
         for (int k = 0; k < na + nb; k++) begin
            if ($urandom_range(0, 1) ? (na > 0) : (nb == 0)) begin
               send_and_gap(OP_APPEND_A, alph >= 255 ? 8'($urandom)
                                         : 8'($urandom_range(0, alph)));
               na--;
            end else begin
               send_and_gap(OP_APPEND_B, alph >= 255 ? 8'($urandom)
                                         : 8'($urandom_range(0, alph)));
               nb--;
            end
            sent++;
         end
         if ($urandom_range(0, 15) == 0) send_and_gap(2'd3, 8'($urandom));
         send_and_gap(OP_COMPUTE, 8'($urandom));
         sent++;
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      len_a = 0; len_b = 0; dropped = 1'b0;
      ratio_limit = RATIO_RESET;
      idle_sender_pause = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_ratio_extremes();
      write_ratio(8'd3);
      test_random(700);
      write_ratio(8'd2);
      test_random(350);
      write_ratio(8'd255);
      test_random(350);

      drain();
      repeat (50) @(negedge clock);
      if (fail_count == 0 && distance_queue.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
